// File: rtl/task_table_engine_unit_defines.svh
// Assertion macros shared by the task table engine RTL.
// Depends on nothing; files that assert include it by name.
`ifndef TASK_TABLE_ENGINE_UNIT_DEFINES_SVH
`define TASK_TABLE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define TTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tte_pkg.sv
// Types, codes and helper functions of the task table engine.
// Depends on nothing; used by the controller, the datapath and the top level.
package tte_pkg;

   typedef enum logic [2:0] {
      CMD_CREATE       = 3'd0,
      CMD_TERMINATE    = 3'd1,
      CMD_BLOCK        = 3'd2,
      CMD_UNBLOCK      = 3'd3,
      CMD_SLEEP        = 3'd4,
      CMD_SET_PRIORITY = 3'd5,
      CMD_QUERY        = 3'd6,
      CMD_COUNT        = 3'd7
   } command_type;

   typedef enum logic [2:0] {
      ST_DONE         = 3'd0,
      ST_NOT_FOUND    = 3'd1,
      ST_TABLE_FULL   = 3'd2,
      ST_IDLE_REFUSED = 3'd3,
      ST_NO_CHANGE    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      TS_READY      = 3'd0,
      TS_RUNNING    = 3'd1,
      TS_BLOCKED    = 3'd2,
      TS_TERMINATED = 3'd3,
      TS_SLEEPING   = 3'd4
   } task_state_type;

   // What a slot walk is looking for.
   typedef enum logic [1:0] {
      MODE_FIND   = 2'd0,
      MODE_CREATE = 2'd1,
      MODE_COUNT  = 2'd2,
      MODE_IDLE   = 2'd3
   } scan_mode_type;

   typedef enum logic [1:0] {
      CS_IDLE   = 2'd0,
      CS_SCAN   = 2'd1,
      CS_FINISH = 2'd2
   } ctl_state_type;

   localparam int          PID_OUT_W   = 16;
   localparam logic [7:0]  PRIO_MAX    = 8'd3;
   localparam logic [4:0]  ACTIVE_MAX  = 5'd31;
   // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit x.
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT = 35;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] target_pid;
      logic [7:0]  priority_in;
      logic [15:0] parent_in;
      logic [31:0] sleep_ms;
      logic [31:0] now_tick;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] result_pid;
      logic [2:0]  task_state;
      logic [7:0]  task_priority;
      logic [3:0]  task_slice;
      logic [15:0] task_parent;
      logic [31:0] wake_tick;
      logic [4:0]  active_count;
   } rsp_payload_type;

   // One table entry without its pid (the pid width is a design parameter).
   typedef struct packed {
      task_state_type state;
      logic [7:0]     prio;
      logic [3:0]     slice;
      logic [15:0]    parent;
      logic [31:0]    wake;
   } slot_entry_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
   } dp_stat_type;

   function automatic logic [3:0] slice_for(input logic [7:0] prio);
      logic [3:0] slice;
      unique case (prio)
         8'd0:    slice = 4'd1;
         8'd1:    slice = 4'd2;
         8'd2:    slice = 4'd4;
         8'd3:    slice = 4'd8;
         default: slice = 4'd2;
      endcase
      return slice;
   endfunction

   // Contents of a slot that has never been written.
   function automatic slot_entry_type reset_entry(input logic is_idle_slot);
      slot_entry_type ent;
      ent          = '0;
      ent.state    = TS_READY;
      ent.slice    = is_idle_slot ? 4'd1 : 4'd0;
      return ent;
   endfunction

endpackage

// File: rtl/tte_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface tte_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tte_ctrl.sv
// Controller state machine of the task table engine: accept, slot walk, finish.
// Depends on tte_pkg; drives the datapath through ctl_cmd_type.
module tte_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tte_pkg::dp_stat_type dp_stat,
   output tte_pkg::ctl_cmd_type ctl_cmd
);
   import tte_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic          rsp_free;

   assign rsp_free = !rsp_vld_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_SCAN;
         end
         CS_SCAN: begin
            if (dp_stat.hit || dp_stat.last) state_in = CS_FINISH;
         end
         CS_FINISH: begin
            if (rsp_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      ctl_cmd   = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready     = 1'b1;
            ctl_cmd.start = req_valid;
         end
         CS_SCAN: begin
            ctl_cmd.scan = 1'b1;
         end
         CS_FINISH: begin
            ctl_cmd.finish = rsp_free;
         end
         default: begin
            ctl_cmd = '0;
         end
      endcase
   end

   // The result register stays full until taken; a finish refills it.
   always_comb begin
      if (ctl_cmd.finish) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CS_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

// File: rtl/tte_datapath.sv
// Datapath of the task table engine: slot memories, walk pipeline, update and result.
// Depends on tte_pkg; steered by the controller through ctl_cmd_type.
module tte_datapath #(
   parameter int TABLE_SLOTS = 16,
   parameter int PID_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tte_pkg::ctl_cmd_type     ctl_cmd,
   input  tte_pkg::req_payload_type req_payload,
   output tte_pkg::dp_stat_type     dp_stat,
   output tte_pkg::rsp_payload_type rsp_payload
);
   import tte_pkg::*;

   localparam int IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CntW = $clog2(TABLE_SLOTS + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SLOTS - 1);

   // Captured request.
   command_type         cmd_ff;
   scan_mode_type       mode_ff, mode_in;
   logic [PID_BITS-1:0] target_ff, target_in;
   logic [7:0]          prio_ff;
   logic [15:0]         parent_ff;
   logic [31:0]         ms_ff;
   logic [31:0]         now_ff;
   logic [28:0]         quot_ff;
   logic [63:0]         prod;

   // Slot walk.
   logic [IdxW-1:0]     issue_idx_ff;
   logic                issue_on_ff;
   logic                rd_pend_ff;
   logic [IdxW-1:0]     rd_idx_ff;
   logic [PID_BITS-1:0] rd_pid_ff;
   slot_entry_type      rd_ent_ff;
   logic                rd_vld_ff;
   logic [PID_BITS-1:0] eff_pid;
   slot_entry_type      eff_ent;
   logic                eff_live;
   logic                match;

   logic                found_ff;
   logic [IdxW-1:0]     found_idx_ff;
   logic [PID_BITS-1:0] found_pid_ff;
   slot_entry_type      found_ent_ff;
   logic [CntW-1:0]     cnt_ff;

   // Table storage.
   logic [PID_BITS-1:0] pid_mem_ff [TABLE_SLOTS];
   slot_entry_type      ent_mem_ff [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] slot_vld_ff;
   logic [PID_BITS-1:0] pid_ctr_ff, pid_ctr_in;

   // Finish step.
   logic [PID_BITS-1:0] new_pid;
   slot_entry_type      new_ent;
   logic                wr_en;
   logic                ctr_adv;
   logic                report_en;
   rsp_payload_type     rsp_in, rsp_ff;

   assign target_in = PID_BITS'(req_payload.target_pid);

   always_comb begin
      priority case (1'b1)
         command_type'(req_payload.command) == CMD_CREATE: mode_in = MODE_CREATE;
         command_type'(req_payload.command) == CMD_COUNT:  mode_in = MODE_COUNT;
         (command_type'(req_payload.command) == CMD_TERMINATE ||
          command_type'(req_payload.command) == CMD_BLOCK) && target_in == '0:
                                                          mode_in = MODE_IDLE;
         default:                                         mode_in = MODE_FIND;
      endcase
   end

   assign prod = 64'(ms_ff) * 64'(DIV10_RECIP);

   // A slot never written reads as its reset contents.
   assign eff_pid  = rd_vld_ff ? rd_pid_ff : '0;
   assign eff_ent  = rd_vld_ff ? rd_ent_ff : reset_entry(rd_idx_ff == '0);
   assign eff_live = eff_ent.state != TS_TERMINATED;

   always_comb begin
      unique case (mode_ff)
         MODE_FIND:   match = (eff_pid == target_ff) && eff_live;
         MODE_CREATE: match = !eff_live || (eff_pid == '0);
         MODE_IDLE:   match = 1'b1;
         MODE_COUNT:  match = 1'b0;
         default:     match = 1'b0;
      endcase
   end

   assign dp_stat.hit  = rd_pend_ff && match;
   assign dp_stat.last = rd_pend_ff && (rd_idx_ff == LastIdx);

   always_ff @(posedge clock) begin
      quot_ff <= prod[63:DIV10_SHIFT];
      if (ctl_cmd.start) begin
         cmd_ff    <= command_type'(req_payload.command);
         mode_ff   <= mode_in;
         target_ff <= target_in;
         prio_ff   <= req_payload.priority_in;
         parent_ff <= req_payload.parent_in;
         ms_ff     <= req_payload.sleep_ms;
         now_ff    <= req_payload.now_tick;
         found_ff  <= 1'b0;
         cnt_ff    <= '0;
      end
      if (ctl_cmd.scan) begin
         if (issue_on_ff) begin
            rd_pid_ff <= pid_mem_ff[issue_idx_ff];
            rd_ent_ff <= ent_mem_ff[issue_idx_ff];
            rd_vld_ff <= slot_vld_ff[issue_idx_ff];
            rd_idx_ff <= issue_idx_ff;
         end
         if (rd_pend_ff && match) begin
            found_ff     <= 1'b1;
            found_idx_ff <= rd_idx_ff;
            found_pid_ff <= eff_pid;
            found_ent_ff <= eff_ent;
         end
         if (rd_pend_ff && mode_ff == MODE_COUNT && eff_pid != '0 && eff_live) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end
      end
      if (ctl_cmd.finish) begin
         rsp_ff <= rsp_in;
         if (wr_en) begin
            pid_mem_ff[found_idx_ff] <= new_pid;
            ent_mem_ff[found_idx_ff] <= new_ent;
         end
      end
   end

   // Walk control, valid bits and the pid counter need a defined reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_idx_ff <= '0;
         issue_on_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         slot_vld_ff  <= '0;
         pid_ctr_ff   <= PID_BITS'(1);
      end else begin
         pid_ctr_ff <= pid_ctr_in;
         if (ctl_cmd.start) begin
            issue_idx_ff <= (mode_in == MODE_CREATE) ? IdxW'(1) : '0;
            issue_on_ff  <= 1'b1;
            rd_pend_ff   <= 1'b0;
         end else if (ctl_cmd.scan) begin
            rd_pend_ff <= issue_on_ff;
            if (issue_on_ff) begin
               if (issue_idx_ff == LastIdx) begin
                  issue_on_ff <= 1'b0;
               end else begin
                  issue_idx_ff <= issue_idx_ff + IdxW'(1);
               end
            end
         end
         if (ctl_cmd.finish && wr_en) begin
            slot_vld_ff[found_idx_ff] <= 1'b1;
         end
      end
   end

   // Pids wrap from the all-ones value back to 1, never to 0.
   always_comb begin
      pid_ctr_in = pid_ctr_ff;
      if (ctl_cmd.finish && ctr_adv) begin
         pid_ctr_in = (pid_ctr_ff == '1) ? PID_BITS'(1) : pid_ctr_ff + PID_BITS'(1);
      end
   end

   always_comb begin
      new_pid   = found_pid_ff;
      new_ent   = found_ent_ff;
      wr_en     = 1'b0;
      ctr_adv   = 1'b0;
      report_en = 1'b0;
      rsp_in    = '0;
      unique case (mode_ff)
         MODE_CREATE: begin
            if (found_ff) begin
               new_pid          = pid_ctr_ff;
               new_ent.state    = TS_READY;
               new_ent.prio     = prio_ff;
               new_ent.slice    = slice_for(prio_ff);
               new_ent.parent   = parent_ff;
               wr_en            = 1'b1;
               ctr_adv          = 1'b1;
               report_en        = 1'b1;
               rsp_in.status    = ST_DONE;
            end else begin
               rsp_in.status = ST_TABLE_FULL;
            end
         end
         MODE_COUNT: begin
            rsp_in.status       = ST_DONE;
            rsp_in.active_count = (32'(cnt_ff) > 32'(ACTIVE_MAX)) ? ACTIVE_MAX : 5'(cnt_ff);
         end
         MODE_IDLE: begin
            report_en     = 1'b1;
            rsp_in.status = ST_IDLE_REFUSED;
         end
         MODE_FIND: begin
            if (!found_ff) begin
               rsp_in.status     = ST_NOT_FOUND;
               rsp_in.result_pid = PID_OUT_W'(target_ff);
            end else begin
               report_en     = 1'b1;
               rsp_in.status = ST_DONE;
               unique case (cmd_ff)
                  CMD_TERMINATE: begin
                     new_ent.state = TS_TERMINATED;
                     wr_en         = 1'b1;
                  end
                  CMD_BLOCK: begin
                     new_ent.state = TS_BLOCKED;
                     wr_en         = 1'b1;
                  end
                  CMD_UNBLOCK: begin
                     if (found_ent_ff.state != TS_BLOCKED) begin
                        rsp_in.status = ST_NO_CHANGE;
                     end else begin
                        new_ent.state = TS_READY;
                        wr_en         = 1'b1;
                     end
                  end
                  CMD_SLEEP: begin
                     new_ent.state = TS_SLEEPING;
                     new_ent.wake  = now_ff + 32'(quot_ff) + 32'd1;
                     wr_en         = 1'b1;
                  end
                  CMD_SET_PRIORITY: begin
                     new_ent.prio  = (prio_ff > PRIO_MAX) ? PRIO_MAX : prio_ff;
                     new_ent.slice = slice_for(new_ent.prio);
                     wr_en         = 1'b1;
                  end
                  CMD_QUERY, CMD_CREATE, CMD_COUNT: begin
                     wr_en = 1'b0;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      if (report_en) begin
         rsp_in.result_pid    = PID_OUT_W'(new_pid);
         rsp_in.task_state    = new_ent.state;
         rsp_in.task_priority = new_ent.prio;
         rsp_in.task_slice    = new_ent.slice;
         rsp_in.task_parent   = new_ent.parent;
         rsp_in.wake_tick     = new_ent.wake;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/task_table_engine_unit.sv
// Channel   | Direction | Handshake     | Item
// ----------+-----------+---------------+----------------------------------------
// req_if    | in        | valid / ready | one task table command
// rsp_if    | out       | valid / ready | one result for each command
//
// The walk over the slot memory reads one slot per cycle and limits how long an item
// takes from acceptance to its result; lookups stop at the first match, count and
// unsuccessful searches read every slot (a create skips slot 0). The next item
// is taken in the cycle after the result is committed.
// Reset is synchronous and active high; the table then reads as all slots free, with
// the idle task in slot 0, through per-slot valid bits, so no clearing pass is needed.
// A new item is accepted while the previous result still waits in the output register;
// the block only stalls at the end of a command if that register has not been taken.
//
// Top level of the task table engine.
// Depends on tte_pkg, tte_chan_if, tte_ctrl, tte_datapath and the assertion macros.
`include "task_table_engine_unit_defines.svh"

module task_table_engine_unit #(
   parameter int TABLE_SLOTS = 16,
   parameter int PID_BITS    = 16
) (
   input logic        clock,
   input logic        reset,
   tte_chan_if.sink   req_if,
   tte_chan_if.source rsp_if
);
   import tte_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;
   logic        req_ready;
   logic        rsp_valid;

   // The controller sequences each command: it accepts an item, lets the datapath
   // walk the slots until a hit or the last slot, then commits the update and the
   // result in the same cycle once the output register is free.
   tte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .dp_stat   (dp_stat),
      .ctl_cmd   (ctl_cmd)
   );

   // The datapath holds the slot memories, the pid counter, the read pipeline of the
   // walk, and the output register that carries the result item.
   tte_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .PID_BITS    (PID_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl_cmd     (ctl_cmd),
      .req_payload (req_if.payload),
      .dp_stat     (dp_stat),
      .rsp_payload (rsp_if.payload)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

   // A result is only committed when the output register can take it.
   `TTE_ASSERT_NOW(a_finish_when_free, ctl_cmd.finish, !rsp_valid || rsp_if.ready, "overwrite")
   // A committed result is offered on the next cycle.
   `TTE_ASSERT_NEXT(a_finish_shows, ctl_cmd.finish, rsp_valid, "committed result not offered")
   // After accepting an item the block works on it and takes no second one at once.
   `TTE_ASSERT_NEXT(a_one_at_a_time, req_if.valid && req_ready, !req_ready, "second item taken")
   // A waiting result stays offered and unchanged until it is taken.
   `TTE_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_if.ready, rsp_valid && $stable(rsp_if.payload), "result changed while waiting")

endmodule
